// File: rtl/kcs_pkg.sv
package kcs_pkg;

	localparam int NUM_CHANNELS_DEF = 64;
	localparam int MAX_KEYS_DEF = 32;
	localparam int CH_W = 6;
	localparam int SLOT_W = 5;
	localparam int VAL_W = 32;
	localparam int FRAC_W = 17;

	// Configuration register indexes.
	localparam logic CFG_START_TIME = 1'b0;
	localparam logic CFG_END_TIME   = 1'b1;

	// Item kinds.
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic load_wr;
		logic rd_issue;
		logic scan_check;
		logic fetch_a;
		logic fetch_b;
		logic div_start;
		logic mul_start;
		logic mul_step;
		logic out_hold;
		logic out_lerp;
		logic out_bind;
		logic out_load;
	} kcs_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic is_sample;
		logic load_ok;
		logic scan_done;
		logic found;
		logic use_hold;
		logic div_done;
		logic mul_done;
	} kcs_sts_t;

endpackage

// File: rtl/kcs_ram.sv
module kcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/kcs_ctrl.sv
module kcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output kcs_pkg::kcs_cmd_t cmd,
	input  kcs_pkg::kcs_sts_t sts
);
	import kcs_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_DEC   = 11'b00000000010,
		ST_SCAN  = 11'b00000000100,
		ST_FETA  = 11'b00000001000,
		ST_WAITA = 11'b00000010000,
		ST_FETB  = 11'b00000100000,
		ST_WAITB = 11'b00001000000,
		ST_DIV   = 11'b00010000000,
		ST_MUL   = 11'b00100000000,
		ST_FIN   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   outv_q;

	assign s_tready = (state_q == ST_IDLE) && !outv_q;
	assign m_tvalid = outv_q;

	// Sequencer for one item at a time.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					cmd.capture = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (!sts.is_sample) begin
					cmd.load_wr = sts.load_ok;
					state_d = ST_IDLE;
				end else begin
					cmd.rd_issue = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_check = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_FETA;
				end
			end
			ST_FETA: begin
				if (!sts.found) begin
					cmd.out_bind = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.fetch_a = 1'b1;
					state_d = ST_WAITA;
				end
			end
			ST_WAITA: begin
				cmd.fetch_b = 1'b1;
				state_d = ST_FETB;
			end
			ST_FETB: begin
				if (sts.use_hold) begin
					cmd.out_hold = 1'b1;
					state_d = ST_OUT;
				end else begin
					state_d = ST_WAITB;
				end
			end
			ST_WAITB: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.mul_start = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.out_lerp = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.out_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				outv_q <= 1'b1;
			end else if (m_tready) begin
				outv_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/kcs_dp.sv
module kcs_dp #(
	parameter int NUM_CHANNELS = kcs_pkg::NUM_CHANNELS_DEF,
	parameter int MAX_KEYS = kcs_pkg::MAX_KEYS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       start_time,
	input  logic [31:0]       end_time,
	input  logic [205:0]      in_data,
	output logic [135:0]      out_data,
	input  kcs_pkg::kcs_cmd_t cmd,
	output kcs_pkg::kcs_sts_t sts
);
	import kcs_pkg::*;

	localparam int KW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int HW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int DEPTH = NUM_CHANNELS * MAX_KEYS;
	localparam int AW = $clog2(DEPTH);

	// Captured item.
	logic               func_q, interp_q, loop_q;
	logic [CH_W-1:0]    ch_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [31:0]        ktime_q, t_q;
	logic signed [31:0] vx_q, vy_q, vz_q, vw_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= in_data[0];
			ch_q     <= in_data[6:1];
			slot_q   <= in_data[11:7];
			ktime_q  <= in_data[43:12];
			interp_q <= in_data[44];
			vx_q     <= in_data[76:45];
			vy_q     <= in_data[108:77];
			vz_q     <= in_data[140:109];
			vw_q     <= in_data[172:141];
			t_q      <= in_data[204:173];
			loop_q   <= in_data[205];
		end
	end

	// Channel tables: key count and blend mode live in a small RAM, and a
	// per-channel valid flag makes a never-loaded channel read as empty.
	logic          chv_q [NUM_CHANNELS];
	logic          ch_ok, slot_ok;
	logic [HW-1:0] ch_idx;
	logic [KW-1:0] slot_idx;
	logic [HW-1:0] cm_raddr;
	logic [CW:0]   cm_rd;

	assign ch_ok    = 32'(ch_q) < 32'(NUM_CHANNELS);
	assign slot_ok  = 32'(slot_q) < 32'(MAX_KEYS);
	assign ch_idx   = HW'(ch_q);
	assign slot_idx = KW'(slot_q);
	// The table is read at the accepting edge, so the data is ready in the
	// decode cycle.
	assign cm_raddr = HW'(in_data[6:1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				chv_q[i] <= 1'b0;
			end
		end else if (cmd.load_wr) begin
			chv_q[ch_idx] <= 1'b1;
		end
	end

	// Key stores.
	logic          we;
	logic [AW-1:0] waddr, raddr, base;
	logic [31:0]   rd_t, rd_x, rd_y, rd_z, rd_w;

	assign we    = cmd.load_wr;
	assign base  = AW'(ch_idx) * AW'(MAX_KEYS);
	assign waddr = base + AW'(slot_idx);

	kcs_ram #(.WIDTH(CW + 1), .DEPTH(NUM_CHANNELS)) u_cm (.clk, .we, .waddr(ch_idx),
		.wdata({interp_q, CW'(slot_idx) + CW'(1)}), .raddr(cm_raddr), .rdata(cm_rd));

	kcs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_t (.clk, .we, .waddr, .wdata(ktime_q),
		.raddr, .rdata(rd_t));
	kcs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_x (.clk, .we, .waddr, .wdata(vx_q),
		.raddr, .rdata(rd_x));
	kcs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_y (.clk, .we, .waddr, .wdata(vy_q),
		.raddr, .rdata(rd_y));
	kcs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_z (.clk, .we, .waddr, .wdata(vz_q),
		.raddr, .rdata(rd_z));
	kcs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_w (.clk, .we, .waddr, .wdata(vw_q),
		.raddr, .rdata(rd_w));

	// Scan: one key read issued per cycle, checked in the following cycle.
	logic [CW-1:0] count_q, rdi_q, chk_q;
	logic [KW-1:0] hit_q;
	logic          found_q, mode_q;
	logic [31:0]   ts_q;
	logic          rd_more;

	assign rd_more = rdi_q < count_q;

	always_comb begin
		raddr = base + AW'(KW'(rdi_q));
		if (cmd.fetch_a) begin
			raddr = base + AW'(hit_q);
		end else if (cmd.fetch_b) begin
			raddr = base + AW'(hit_q) + AW'(1);
		end
	end

	logic chk_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rdi_q   <= '0;
			chk_q   <= '0;
			chk_v_q <= 1'b0;
			found_q <= 1'b0;
			hit_q   <= '0;
			mode_q  <= 1'b0;
			ts_q    <= '0;
		end else if (cmd.rd_issue) begin
			count_q <= (ch_ok && chv_q[ch_idx]) ? cm_rd[CW-1:0] : '0;
			mode_q  <= (ch_ok && chv_q[ch_idx]) ? cm_rd[CW] : 1'b0;
			rdi_q   <= '0;
			chk_v_q <= 1'b0;
			found_q <= 1'b0;
			ts_q    <= (loop_q && (t_q > end_time)) ? start_time : t_q;
		end else if (cmd.scan_check) begin
			chk_v_q <= rd_more;
			chk_q   <= rdi_q;
			if (rd_more) begin
				rdi_q <= rdi_q + CW'(1);
			end
			if (chk_v_q && (ts_q > rd_t)) begin
				found_q <= 1'b1;
				hit_q   <= KW'(chk_q);
			end
		end
	end

	// Key a and key b capture.
	logic [31:0]        ta_q;
	logic signed [31:0] ax_q, ay_q, az_q, aw_q, bx_q, by_q, bz_q, bw_q;
	logic [31:0]        den_q;
	logic               fb_q;

	always_ff @(posedge clk) begin
		fb_q <= cmd.fetch_b;
		if (cmd.fetch_b) begin
			ta_q <= rd_t;
			ax_q <= rd_x;
			ay_q <= rd_y;
			az_q <= rd_z;
			aw_q <= rd_w;
		end
		if (fb_q) begin
			den_q <= rd_t - ta_q;
			bx_q  <= rd_x;
			by_q  <= rd_y;
			bz_q  <= rd_z;
			bw_q  <= rd_w;
		end
	end

	// Restoring divider: f = (num << 16) / den, one quotient bit per cycle.
	logic [48:0] rem_q;
	logic [47:0] numsh_q;
	logic [47:0] quo_q;
	logic [5:0]  dcnt_q;
	logic        dbusy_q;
	logic [48:0] rtry;

	assign rtry = {rem_q[47:0], numsh_q[47]} - {17'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q  <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			numsh_q <= '0;
		end else if (cmd.div_start) begin
			dbusy_q <= 1'b1;
			dcnt_q  <= 6'd48;
			rem_q   <= '0;
			quo_q   <= '0;
			numsh_q <= {ts_q - ta_q, 16'd0};
		end else if (dbusy_q) begin
			numsh_q <= {numsh_q[46:0], 1'b0};
			if (!rtry[48]) begin
				rem_q <= rtry;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[47:0], numsh_q[47]};
				quo_q <= {quo_q[46:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 6'd1;
			if (dcnt_q == 6'd1) begin
				dbusy_q <= 1'b0;
			end
		end
	end

	// Lerp: one component multiplied per cycle.
	logic [FRAC_W-1:0]  f_q;
	logic [2:0]         mcnt_q;
	logic signed [32:0] d;
	logic signed [50:0] p;
	logic signed [34:0] q;
	logic signed [31:0] ma, r [4];

	always_comb begin
		unique case (mcnt_q[1:0])
			2'd0: begin ma = ax_q; d = 33'(bx_q) - 33'(ax_q); end
			2'd1: begin ma = ay_q; d = 33'(by_q) - 33'(ay_q); end
			2'd2: begin ma = az_q; d = 33'(bz_q) - 33'(az_q); end
			default: begin ma = aw_q; d = 33'(bw_q) - 33'(aw_q); end
		endcase
		p = 51'(d) * $signed({34'd0, f_q});
		q = 35'(p >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
			f_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				r[i] <= '0;
			end
		end else if (cmd.mul_start) begin
			mcnt_q <= '0;
			f_q    <= (quo_q > 48'd65536) ? FRAC_W'(65536) : FRAC_W'(quo_q);
		end else if (cmd.mul_step) begin
			r[mcnt_q[1:0]] <= 32'(35'(ma) + q);
			mcnt_q         <= mcnt_q + 3'd1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_bind) begin
			out_data <= {7'd0, 1'b1, vw_q, vz_q, vy_q, vx_q};
		end else if (cmd.out_hold) begin
			out_data <= {7'd0, 1'b0, aw_q, az_q, ay_q, ax_q};
		end else if (cmd.out_lerp) begin
			out_data <= {7'd0, 1'b0, r[3], r[2], r[1], r[0]};
		end
	end

	assign sts.is_sample = func_q == FUNC_SAMPLE;
	assign sts.load_ok   = ch_ok && slot_ok;
	assign sts.scan_done = !rd_more && !chk_v_q && cmd.scan_check;
	assign sts.found     = found_q;
	assign sts.use_hold  = (CW'(hit_q) + CW'(1) >= count_q) || !mode_q;
	assign sts.div_done  = !dbusy_q && !cmd.div_start;
	assign sts.mul_done  = mcnt_q == 3'd3;

endmodule

// File: rtl/keyframe_curve_sampler.sv
// Piecewise linear keyframe sampler with one curve per channel. Load items
// (func 0) store one keyframe and return nothing; sample items (func 1) return
// one result. One transaction is handled at a time, and the next is accepted
// only once the previous result has been taken. A load writes its key in the
// decode state. A sample scans the channel's count keys through the key store's
// read port, one per cycle. m_tvalid rises once the result is registered:
// right after the scan when no key qualifies, after keys a and b are
// fetched when a key's value is held, and after the serial divider and the
// shared lerp multiplier when it blends. Configuration: index 0 start_time,
// index 1 end_time.
module keyframe_curve_sampler #(
	parameter int NUM_CHANNELS = kcs_pkg::NUM_CHANNELS_DEF,
	parameter int MAX_KEYS = kcs_pkg::MAX_KEYS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// func, channel, key_index, key_time, interp_enable, val_x, val_y, val_z,
	// val_w, sample_time, loop_enable
	input  logic [207:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z, out_w, from_bind
	output logic [135:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import kcs_pkg::*;

	logic [31:0] start_q, end_q;
	kcs_cmd_t    cmd;
	kcs_sts_t    sts;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_START_TIME) begin
				start_q <= cfg_data;
			end else begin
				end_q <= cfg_data;
			end
		end
	end

	kcs_ctrl u_ctrl (.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
		.cmd, .sts);

	kcs_dp #(.NUM_CHANNELS(NUM_CHANNELS), .MAX_KEYS(MAX_KEYS)) u_dp (
		.clk, .arst_n, .start_time(start_q), .end_time(end_q),
		.in_data(s_tdata[205:0]), .out_data(m_tdata), .cmd, .sts);

endmodule
